FILE: rtl/core/irss_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the intra reference sample smoother.
package irss_pkg;

  localparam int DATA_W    = 16;
  localparam int IDX_W     = 9;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 3;
  localparam int LOG2_W    = 3;
  localparam int DEPTH_W   = 5;
  // Strong threshold tops out at 1 << (16 - 5).
  localparam int THR_W     = 12;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_LOG2     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRONG_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 3'd3;

  localparam logic [LOG2_W-1:0]  MIN_LOG2      = 3'd2;
  localparam logic [LOG2_W-1:0]  STRONG_LOG2   = 3'd5;
  localparam int                 STRONG_LOG2_I = 5;
  localparam logic [DEPTH_W-1:0] BD_MIN        = 5'd8;
  localparam logic [DEPTH_W-1:0] BD_MAX        = 5'd16;
  localparam logic [DEPTH_W-1:0] THR_BIAS      = 5'd5;

  typedef logic [DATA_W-1:0] sample_t;
  typedef logic [IDX_W-1:0]  index_t;

  typedef struct packed {
    index_t              idx;
    logic [LOG2_W-1:0]   log2n;
    logic [DEPTH_W-1:0]  bit_depth;
    logic                strong_enable;
    logic                filter_enable;
  } calc_req_t;

  typedef struct packed {
    sample_t prev;
    sample_t cur;
    sample_t next;
  } nbr_t;

  typedef struct packed {
    sample_t bl;
    sample_t mid_left;
    sample_t corner;
    sample_t mid_top;
    sample_t tr;
  } anchor_t;

  typedef struct packed {
    sample_t value;
    logic    strong_flag;
    logic    out_of_range;
  } calc_res_t;

endpackage

FILE: rtl/core/irss_ram.sv
`timescale 1ns / 1ps
// Generic single-write, dual-read RAM with registered read data.
module irss_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 129,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr0,
  input  logic [ADDR_W-1:0] raddr1,
  output logic [WIDTH-1:0]  rdata0,
  output logic [WIDTH-1:0]  rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

FILE: rtl/core/irss_calc.sv
`timescale 1ns / 1ps
// Filter datapath: [1 2 1] smoothing, flatness test and bilinear strong smoothing.
module irss_calc (
  input  irss_pkg::calc_req_t req,
  input  irss_pkg::nbr_t      nbr,
  input  irss_pkg::anchor_t   anch,
  output irss_pkg::calc_res_t res
);
  import irss_pkg::*;

  localparam int SUM_W  = DATA_W + 2;
  localparam int DIFF_W = DATA_W + 1;
  localparam int OFF_W  = IDX_W + 1;
  localparam int PROD_W = DIFF_W + OFF_W;

  index_t                    n;
  index_t                    n2;
  index_t                    last;
  index_t                    off;
  logic [DEPTH_W-1:0]        bd;
  logic [THR_W-1:0]          thr;
  logic signed [SUM_W-1:0]   flat_l;
  logic signed [SUM_W-1:0]   flat_t;
  logic [SUM_W-1:0]          mag_l;
  logic [SUM_W-1:0]          mag_t;
  logic                      strong_sel;
  logic                      lower;
  logic                      oor;
  sample_t                   a;
  sample_t                   b;
  logic signed [DIFF_W-1:0]  slope;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  biased;
  logic signed [PROD_W-1:0]  ramp;
  logic signed [PROD_W-1:0]  interp;
  logic [SUM_W-1:0]          tap_sum;

  assign n    = index_t'(1) << req.log2n;
  assign n2   = n << 1;
  assign last = n << 2;
  assign oor  = req.idx > last;

  always_comb begin
    bd = req.bit_depth;
    if (req.bit_depth < BD_MIN) begin
      bd = BD_MIN;
    end else if (req.bit_depth > BD_MAX) begin
      bd = BD_MAX;
    end
  end

  assign thr = THR_W'(1) << (bd - THR_BIAS);

  // Second differences along the left column and the top row
  assign flat_l = signed'({2'b00, anch.bl}) + signed'({2'b00, anch.corner})
                - signed'({1'b0, anch.mid_left, 1'b0});
  assign flat_t = signed'({2'b00, anch.corner}) + signed'({2'b00, anch.tr})
                - signed'({1'b0, anch.mid_top, 1'b0});
  assign mag_l  = flat_l < 0 ? SUM_W'(-flat_l) : SUM_W'(flat_l);
  assign mag_t  = flat_t < 0 ? SUM_W'(-flat_t) : SUM_W'(flat_t);

  assign strong_sel = req.filter_enable && req.strong_enable && (req.log2n >= STRONG_LOG2)
                   && (mag_l < SUM_W'(thr)) && (mag_t < SUM_W'(thr));

  // a + ((b - a) * off + N) >>> (log2N + 1); the corner falls out with off = 0
  assign lower  = req.idx < n2;
  assign a      = lower ? anch.bl : anch.corner;
  assign b      = lower ? anch.corner : anch.tr;
  assign off    = lower ? req.idx : req.idx - n2;
  assign slope  = signed'({1'b0, b}) - signed'({1'b0, a});
  assign prod   = PROD_W'(slope) * PROD_W'(signed'({1'b0, off}));
  assign biased = prod + PROD_W'(signed'({1'b0, n}));
  assign ramp   = biased >>> (4'(req.log2n) + 4'd1);
  assign interp = ramp + PROD_W'(signed'({1'b0, a}));

  assign tap_sum = {2'b00, nbr.prev} + {1'b0, nbr.cur, 1'b0} + {2'b00, nbr.next}
                 + SUM_W'(2);

  always_comb begin
    res.out_of_range = oor;
    res.strong_flag  = 1'b0;
    res.value        = '0;
    if (!oor) begin
      res.strong_flag = strong_sel;
      if (!req.filter_enable || req.idx == '0 || req.idx == last) begin
        res.value = nbr.cur;
      end else if (strong_sel) begin
        res.value = interp[DATA_W-1:0];
      end else begin
        res.value = tap_sum[SUM_W-1:2];
      end
    end
  end

endmodule

FILE: rtl/core/intra_reference_sample_smoother_unit.sv
`timescale 1ns / 1ps
// Intra reference sample smoother: takes one write or read transfer per cycle unless stalled.
// A write stores one reference sample; a read passes the bank read stage and the output
// register; back-to-back reads stream at one per cycle unless stalled. The rate is set by the
// sample store, split into even and odd banks with two read ports each so that a sample and
// both neighbours come out of one access; the five strong-smoothing anchors of each large
// block size are mirrored in flip-flops. The store needs no clearing pass after reset.
module intra_reference_sample_smoother_unit #(
  parameter int MAX_BLOCK_SIZE = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [irss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irss_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           cmd,
  input  logic [irss_pkg::IDX_W-1:0]     sample_index,
  input  logic [irss_pkg::DATA_W-1:0]    sample_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [irss_pkg::DATA_W-1:0]    filtered_value,
  output logic                           strong_used,
  output logic                           out_of_range
);
  import irss_pkg::*;

  localparam int MAX_LOG2   = $clog2(MAX_BLOCK_SIZE + 1) - 1;
  localparam int EVEN_DEPTH = 2 * MAX_BLOCK_SIZE + 1;
  localparam int ODD_DEPTH  = 2 * MAX_BLOCK_SIZE;
  localparam int EVEN_AW    = $clog2(EVEN_DEPTH);
  localparam int ODD_AW     = $clog2(ODD_DEPTH);
  localparam int HALF_W     = IDX_W - 1;
  localparam int NUM_SETS   = (MAX_LOG2 >= STRONG_LOG2_I) ? MAX_LOG2 - STRONG_LOG2_I + 1 : 1;
  localparam int SET_W      = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int ANCHORS    = 5;

  // configuration
  logic [DEPTH_W-1:0] bit_depth;
  logic [LOG2_W-1:0]  size_log2;
  logic               strong_enable;
  logic               filter_enable;

  logic [LOG2_W-1:0]  log2n;
  index_t             last;
  logic               advance;
  logic               in_take;
  logic               rd_take;
  logic               wr_take;
  logic [HALF_W-1:0]  half;
  logic [HALF_W-1:0]  half_dec;
  logic [IDX_W-1:0]   half_inc;

  logic               s1_valid;
  index_t             s1_idx;

  sample_t            even_rd0;
  sample_t            even_rd1;
  sample_t            odd_rd0;
  sample_t            odd_rd1;

  sample_t            anchor_q [NUM_SETS][ANCHORS];
  logic [LOG2_W-1:0]  set_off;
  logic [SET_W-1:0]   set_sel;

  calc_req_t          req;
  nbr_t               nbr;
  anchor_t            anch;
  calc_res_t          res;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_depth     <= 5'd8;
      size_log2     <= 3'd2;
      strong_enable <= 1'b0;
      filter_enable <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BIT_DEPTH:     bit_depth     <= cfg_data[DEPTH_W-1:0];
        REG_SIZE_LOG2:     size_log2     <= cfg_data[LOG2_W-1:0];
        REG_STRONG_ENABLE: strong_enable <= cfg_data[0];
        REG_FILTER_ENABLE: filter_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    log2n = size_log2;
    if (size_log2 < MIN_LOG2) begin
      log2n = MIN_LOG2;
    end else if (size_log2 > LOG2_W'(MAX_LOG2)) begin
      log2n = LOG2_W'(MAX_LOG2);
    end
  end

  assign last = index_t'(1) << (4'(log2n) + 4'd2);

  // Stage 1 moves on whenever the output register is free or being emptied
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;
  assign rd_take  = in_take && (cmd == CMD_READ);
  assign wr_take  = in_take && (cmd == CMD_WRITE) && (sample_index <= last);

  assign half     = sample_index[IDX_W-1:1];
  assign half_dec = half - HALF_W'(1);
  assign half_inc = {1'b0, half} + IDX_W'(1);

  // Even index: cur = even[h], prev = odd[h-1], next = odd[h].
  // Odd index:  cur = odd[h],  prev = even[h],  next = even[h+1].
  irss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (EVEN_DEPTH)
  ) u_even_bank (
    .clk    (clk),
    .we     (wr_take && !sample_index[0]),
    .waddr  (half[EVEN_AW-1:0]),
    .wdata  (sample_value),
    .re     (rd_take),
    .raddr0 (half[EVEN_AW-1:0]),
    .raddr1 (half_inc[EVEN_AW-1:0]),
    .rdata0 (even_rd0),
    .rdata1 (even_rd1)
  );

  irss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ODD_DEPTH)
  ) u_odd_bank (
    .clk    (clk),
    .we     (wr_take && sample_index[0]),
    .waddr  (half[ODD_AW-1:0]),
    .wdata  (sample_value),
    .re     (rd_take),
    .raddr0 (sample_index[0] ? half[ODD_AW-1:0] : half_dec[ODD_AW-1:0]),
    .raddr1 (half[ODD_AW-1:0]),
    .rdata0 (odd_rd0),
    .rdata1 (odd_rd1)
  );

  // Anchor copies at positions 0, N, 2N, 3N, 4N for every block size that allows strong mode
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_SETS; k++) begin
      for (int j = 0; j < ANCHORS; j++) begin
        if (wr_take && sample_index == IDX_W'(j << (STRONG_LOG2_I + k))) begin
          anchor_q[k][j] <= sample_value;
        end
      end
    end
  end

  assign set_off = log2n - STRONG_LOG2;
  assign set_sel = set_off[SET_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= rd_take;
    end
    if (rd_take) begin
      s1_idx <= sample_index;
    end
  end

  always_comb begin
    req.idx           = s1_idx;
    req.log2n         = log2n;
    req.bit_depth     = bit_depth;
    req.strong_enable = strong_enable;
    req.filter_enable = filter_enable;
    if (s1_idx[0]) begin
      nbr.cur  = odd_rd0;
      nbr.prev = even_rd0;
      nbr.next = even_rd1;
    end else begin
      nbr.cur  = even_rd0;
      nbr.prev = odd_rd0;
      nbr.next = odd_rd1;
    end
    anch.bl       = anchor_q[set_sel][0];
    anch.mid_left = anchor_q[set_sel][1];
    anch.corner   = anchor_q[set_sel][2];
    anch.mid_top  = anchor_q[set_sel][3];
    anch.tr       = anchor_q[set_sel][4];
  end

  irss_calc u_calc (
    .req  (req),
    .nbr  (nbr),
    .anch (anch),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
    if (advance && s1_valid) begin
      filtered_value <= res.value;
      strong_used    <= res.strong_flag;
      out_of_range   <= res.out_of_range;
    end
  end

endmodule

FILE: rtl/core/irss_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the reference sample smoother, bound to the top level.
module irss_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [irss_pkg::DATA_W-1:0] filtered_value,
  input logic                        strong_used,
  input logic                        out_of_range
);
  import irss_pkg::*;

  // A stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(filtered_value)
                               && $stable(strong_used) && $stable(out_of_range))
    else $error("result changed while stalled");

  // Out-of-range reads carry a zero sample and no strong flag
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> filtered_value == '0 && !strong_used)
    else $error("out-of-range result not cleared");

  // An empty output register never back-pressures the input
  a_skid: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with output register empty");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind intra_reference_sample_smoother_unit irss_checker u_irss_checker (.*);
